FILE: design/rbbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbbc_pkg
// Types, codes and constants shared by the two-LED breathing and blinking
// controller.
// ----------------------------------------------------------------------------
package rbbc_pkg;

	localparam int NUM_CH      = 6;
	localparam int CH_PER_LED  = 3;
	localparam int DUTY_W      = 8;
	localparam int TIME_W      = 32;
	localparam int CFG_IDX_W   = 2;

	localparam logic [DUTY_W-1:0] DUTY_MAX        = '1;
	localparam logic [DUTY_W-1:0] DUTY_TOP_RST    = 8'd100;
	localparam logic [DUTY_W-1:0] DUTY_BOTTOM_RST = 8'd10;

	localparam int BLINK_PERIOD  = 500;
	localparam int BLINK_HALF    = 250;
	localparam int BLINK_QUARTER = BLINK_PERIOD / 4;
	localparam int RECIP_SHIFT   = 37;
	localparam int RECIP_W       = 31;
	localparam int QUOT_W        = TIME_W - 2 + RECIP_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] BLINK_RECIP =
		RECIP_W'((64'd1 << RECIP_SHIFT) / BLINK_QUARTER);
	localparam int PHASE_W = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_TOP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_BOTTOM = 2'd1;

	localparam logic [1:0] LED_ONE = 2'd1;
	localparam logic [1:0] LED_TWO = 2'd2;

	localparam logic [1:0] COLOUR_RED    = 2'd0;
	localparam logic [1:0] COLOUR_GREEN  = 2'd1;
	localparam logic [1:0] COLOUR_BLUE   = 2'd2;
	localparam logic [1:0] COLOUR_YELLOW = 2'd3;

	typedef enum logic [1:0] {
		REQ_SET  = 2'd0,
		REQ_TICK = 2'd1,
		REQ_EVAL = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_ON     = 2'd1,
		MODE_BREATH = 2'd2,
		MODE_BLINK  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [1:0]        led_sel;
		logic [1:0]        colour;
		logic [1:0]        mode;
		logic [TIME_W-1:0] time_ms;
		logic [DUTY_W-1:0] pwm_red_one;
		logic [DUTY_W-1:0] pwm_green_one;
		logic [DUTY_W-1:0] pwm_blue_one;
		logic [DUTY_W-1:0] pwm_red_two;
		logic [DUTY_W-1:0] pwm_green_two;
		logic [DUTY_W-1:0] pwm_blue_two;
	} item_word_t;

	typedef struct packed {
		logic pin_red_one;
		logic pin_green_one;
		logic pin_blue_one;
		logic pin_red_two;
		logic pin_green_two;
		logic pin_blue_two;
	} pins_word_t;

	typedef struct packed {
		req_t              req;
		logic              set_en;
		mode_t             set_mode;
		logic [DUTY_W-1:0] pwm;
		logic              blink;
	} lane_ctrl_t;

	// Whether a colour code lights the channel at a given place within an LED.
	function automatic logic colour_lit(input logic [1:0] colour, input logic [1:0] pos);
		logic lit;
		lit = 1'b0;
		case (pos)
			2'd0:    lit = (colour == COLOUR_RED) || (colour == COLOUR_YELLOW);
			2'd1:    lit = (colour == COLOUR_GREEN) || (colour == COLOUR_YELLOW);
			2'd2:    lit = (colour == COLOUR_BLUE);
			default: lit = 1'b0;
		endcase
		return lit;
	endfunction

endpackage

FILE: design/rbbc_blink.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbbc_blink
// Two-stage blink phase unit: works out time modulo the blink period by a
// reciprocal multiplication with one correction step.
// ----------------------------------------------------------------------------
module rbbc_blink
	import rbbc_pkg::*;
(
	input  logic              clk,
	input  logic              adv,
	input  logic [TIME_W-1:0] time_ms,
	output logic              blink
);

	logic [TIME_W-3:0]          quarter_in;
	logic [TIME_W-2+RECIP_W-1:0] prod;
	logic [QUOT_W-1:0]          quot_s1;
	logic [7:0]                 quarter_lo_s1;
	logic [1:0]                 low_s1;
	logic [7:0]                 rem_raw;
	logic [6:0]                 rem_fix;
	logic [PHASE_W-1:0]         phase_s2;

	// Period is four times the quarter, so only the upper bits need dividing.
	assign quarter_in = time_ms[TIME_W-1:2];
	assign prod       = quarter_in * BLINK_RECIP;

	always_ff @(posedge clk) begin
		if (adv) begin
			quot_s1       <= prod[TIME_W-2+RECIP_W-1:RECIP_SHIFT];
			quarter_lo_s1 <= quarter_in[7:0];
			low_s1        <= time_ms[1:0];
		end
	end

	// The estimate is low by at most one, so the remainder stays below twice
	// the divisor and fits in eight bits.
	assign rem_raw = quarter_lo_s1 - 8'(quot_s1[7:0] * 8'(BLINK_QUARTER));
	assign rem_fix = (rem_raw >= 8'(BLINK_QUARTER)) ? 7'(rem_raw - 8'(BLINK_QUARTER))
	                                                 : rem_raw[6:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			phase_s2 <= {rem_fix, low_s1};
		end
	end

	assign blink = (phase_s2 > PHASE_W'(BLINK_HALF));

endmodule

FILE: design/rbbc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbbc_lane
// One LED channel: holds its mode, breathing duty and ramp direction, and
// latches its pin on an evaluate word.
// ----------------------------------------------------------------------------
module rbbc_lane
	import rbbc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  lane_ctrl_t        ctrl,
	input  logic [DUTY_W-1:0] duty_top,
	input  logic [DUTY_W-1:0] duty_bottom,
	output logic              pin
);

	mode_t             mode_q, mode_d;
	logic [DUTY_W-1:0] duty_q, duty_d;
	logic              down_q, down_d;
	logic              pin_q, pin_d;

	always_comb begin
		logic [DUTY_W-1:0] duty_up;
		logic              down_mid;
		mode_d   = mode_q;
		duty_d   = duty_q;
		down_d   = down_q;
		pin_d    = pin_q;
		duty_up  = duty_q;
		down_mid = down_q;
		case (ctrl.req)
			REQ_SET: begin
				if (ctrl.set_en) begin
					mode_d = ctrl.set_mode;
				end
			end
			REQ_TICK: begin
				if (mode_q == MODE_BREATH) begin
					if (!down_q) begin
						duty_up  = (duty_q != DUTY_MAX) ? duty_q + 1'b1 : duty_q;
						down_mid = (duty_up >= duty_top);
					end
					duty_d = duty_up;
					down_d = down_mid;
					if (down_mid) begin
						duty_d = (duty_up != '0) ? duty_up - 1'b1 : duty_up;
						down_d = !(duty_d <= duty_bottom);
					end
				end
			end
			REQ_EVAL: begin
				case (mode_q)
					MODE_OFF:    pin_d = 1'b0;
					MODE_ON:     pin_d = 1'b1;
					MODE_BREATH: pin_d = (ctrl.pwm >= duty_q);
					MODE_BLINK:  pin_d = ctrl.blink;
					default:     pin_d = 1'b0;
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OFF;
			duty_q <= '0;
			down_q <= 1'b0;
			pin_q  <= 1'b0;
		end else if (en) begin
			mode_q <= mode_d;
			duty_q <= duty_d;
			down_q <= down_d;
			pin_q  <= pin_d;
		end
	end

	assign pin = pin_q;

endmodule

FILE: design/rgb_led_breath_blink_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_led_breath_blink_controller
// Six channel lanes under one command decoder, with a blink phase pipeline
// and an output register that gathers the latched pins of both LEDs.
// ----------------------------------------------------------------------------
// An accepted item word passes item_s1 and item_s2, then the lane pin latches.
// Throughput: one word per cycle; the blink phase pipeline sets the depth.
// The whole pipeline holds while a finished pins word is stalled.
// Reset: all channels off, duties zero and ramping up, pins dark, limits 100/10.
// ----------------------------------------------------------------------------
module rgb_led_breath_blink_controller
	import rbbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_word_t           item,
	output logic                 pins_valid,
	input  logic                 pins_stall,
	output pins_word_t           pins,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [DUTY_W-1:0]    cfg_data
);

	logic              adv;
	logic              valid_s1, valid_s2, out_valid_q;
	item_word_t        item_s1, item_s2;
	logic              blink;
	logic [DUTY_W-1:0] duty_top_q, duty_bottom_q;
	logic [DUTY_W-1:0] pwm_s2 [NUM_CH];
	logic [NUM_CH-1:0] pin;
	lane_ctrl_t        ctrl [NUM_CH];

	assign adv        = !out_valid_q || !pins_stall;
	assign item_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_top_q    <= DUTY_TOP_RST;
			duty_bottom_q <= DUTY_BOTTOM_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_DUTY_TOP:    duty_top_q    <= cfg_data;
				CFG_DUTY_BOTTOM: duty_bottom_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= item_valid;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= item;
			item_s2 <= item_s1;
		end
	end

	rbbc_blink u_blink (
		.clk     (clk),
		.adv     (adv),
		.time_ms (item.time_ms),
		.blink   (blink)
	);

	assign pwm_s2[0] = item_s2.pwm_red_one;
	assign pwm_s2[1] = item_s2.pwm_green_one;
	assign pwm_s2[2] = item_s2.pwm_blue_one;
	assign pwm_s2[3] = item_s2.pwm_red_two;
	assign pwm_s2[4] = item_s2.pwm_green_two;
	assign pwm_s2[5] = item_s2.pwm_blue_two;

	for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
		localparam logic [1:0] LANE_LED = (i < CH_PER_LED) ? LED_ONE : LED_TWO;
		localparam logic [1:0] LANE_POS = 2'(i % CH_PER_LED);

		always_comb begin
			ctrl[i].req      = req_t'(item_s2.req_type);
			ctrl[i].set_en   = (item_s2.led_sel == LANE_LED);
			ctrl[i].set_mode = colour_lit(item_s2.colour, LANE_POS) ? mode_t'(item_s2.mode)
			                                                        : MODE_OFF;
			ctrl[i].pwm      = pwm_s2[i];
			ctrl[i].blink    = blink;
		end

		rbbc_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (adv && valid_s2),
			.ctrl        (ctrl[i]),
			.duty_top    (duty_top_q),
			.duty_bottom (duty_bottom_q),
			.pin         (pin[i])
		);
	end

	// The lane latches only change when a word moves into the output slot,
	// so they serve directly as the output payload.
	assign pins_valid         = out_valid_q;
	assign pins.pin_red_one   = pin[0];
	assign pins.pin_green_one = pin[1];
	assign pins.pin_blue_one  = pin[2];
	assign pins.pin_red_two   = pin[3];
	assign pins.pin_green_two = pin[4];
	assign pins.pin_blue_two  = pin[5];

endmodule

FILE: design/rbbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbbc_checker
// Port-level checks on the controller's handshakes and pipeline timing.
// ----------------------------------------------------------------------------
module rbbc_checker
	import rbbc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       item_valid,
	input logic       item_stall,
	input logic       pins_valid,
	input logic       pins_stall,
	input pins_word_t pins
);

	a_pins_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pins_valid && pins_stall |=> pins_valid && $stable(pins))
		else $error("Stalled pins word was not held.");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> pins_valid && pins_stall)
		else $error("Input stalled without a stalled pins word.");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) ##1 !pins_stall ##1 !pins_stall |=> pins_valid)
		else $error("Accepted word did not reach the output in three cycles.");

	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !pins_valid)
		else $error("Pins word present straight after reset.");

endmodule

bind rgb_led_breath_blink_controller rbbc_checker u_rbbc_checker (.*);

FILE: tb/rbbc_pins_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbbc_pins_checker
// Watches the item, pins and configuration ports of the breathing and blinking
// controller. It keeps its own copy of the six channels and the duty limits,
// predicts the pins word for every accepted item word and compares each pins
// word that leaves the block, pin by pin, with the oldest prediction.
// ----------------------------------------------------------------------------
module rbbc_pins_checker
	import rbbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_stall,
	input  item_word_t           item,
	input  logic                 pins_valid,
	input  logic                 pins_stall,
	input  pins_word_t           pins,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [DUTY_W-1:0]    cfg_data,
	output int                   fail_count,
	output int                   open_words,
	output int                   checked_words
);

	localparam logic [TIME_W-1:0] PERIOD_MS = TIME_W'(BLINK_PERIOD);
	localparam logic [TIME_W-1:0] HALF_MS   = TIME_W'(BLINK_HALF);

	mode_t             chan_mode [NUM_CH];
	logic [DUTY_W-1:0] chan_duty [NUM_CH];
	logic              ramp_dn   [NUM_CH];
	logic              pin_latch [NUM_CH];
	logic [DUTY_W-1:0] top_lim;
	logic [DUTY_W-1:0] bot_lim;
	pins_word_t        pins_expected [$];
	string             pin_names [NUM_CH] = '{"pin_red_one", "pin_green_one", "pin_blue_one",
		"pin_red_two", "pin_green_two", "pin_blue_two"};

	task automatic log_failure(input string what);
		fail_count++;
		$display("[%0t] mismatch %0d: %s", $time, fail_count, what);
	endtask

	task automatic apply_item(input item_word_t w);
		int                base;
		logic              lit;
		logic              blink;
		logic [DUTY_W-1:0] pwm [NUM_CH];
		logic [NUM_CH-1:0] bits;
		case (req_t'(w.req_type))
			REQ_SET: begin
				if (w.led_sel == LED_ONE || w.led_sel == LED_TWO) begin
					base = (w.led_sel == LED_ONE) ? 0 : CH_PER_LED;
					for (int c = 0; c < CH_PER_LED; c++) begin
						if (c == 0) begin
							lit = (w.colour == COLOUR_RED) || (w.colour == COLOUR_YELLOW);
						end else if (c == 1) begin
							lit = (w.colour == COLOUR_GREEN) || (w.colour == COLOUR_YELLOW);
						end else begin
							lit = (w.colour == COLOUR_BLUE);
						end
						chan_mode[base + c] = lit ? mode_t'(w.mode) : MODE_OFF;
					end
				end
			end
			REQ_TICK: begin
				for (int i = 0; i < NUM_CH; i++) begin
					if (chan_mode[i] == MODE_BREATH) begin
						if (!ramp_dn[i]) begin
							if (chan_duty[i] != DUTY_MAX) chan_duty[i] = chan_duty[i] + 1'b1;
							if (chan_duty[i] >= top_lim) ramp_dn[i] = 1'b1;
						end
						if (ramp_dn[i]) begin
							if (chan_duty[i] != '0) chan_duty[i] = chan_duty[i] - 1'b1;
							if (chan_duty[i] <= bot_lim) ramp_dn[i] = 1'b0;
						end
					end
				end
			end
			REQ_EVAL: begin
				blink = (w.time_ms % PERIOD_MS) > HALF_MS;
				pwm = '{w.pwm_red_one, w.pwm_green_one, w.pwm_blue_one,
					w.pwm_red_two, w.pwm_green_two, w.pwm_blue_two};
				for (int i = 0; i < NUM_CH; i++) begin
					case (chan_mode[i])
						MODE_OFF:    pin_latch[i] = 1'b0;
						MODE_ON:     pin_latch[i] = 1'b1;
						MODE_BREATH: pin_latch[i] = (pwm[i] >= chan_duty[i]);
						default:     pin_latch[i] = blink;
					endcase
				end
			end
			default: begin
			end
		endcase
		for (int i = 0; i < NUM_CH; i++) begin
			bits[NUM_CH-1-i] = pin_latch[i];
		end
		pins_expected.push_back(pins_word_t'(bits));
	endtask

	task automatic compare_pins(input pins_word_t got);
		logic [NUM_CH-1:0] want;
		logic [NUM_CH-1:0] seen;
		if (pins_expected.size() == 0) begin
			log_failure($sformatf("pins word %b arrived with no prediction waiting", got));
		end else begin
			want = pins_expected.pop_front();
			seen = got;
			checked_words++;
			for (int i = 0; i < NUM_CH; i++) begin
				if (seen[NUM_CH-1-i] !== want[NUM_CH-1-i]) begin
					log_failure($sformatf("word %0d %s expected %b got %b", checked_words,
						pin_names[i], want[NUM_CH-1-i], seen[NUM_CH-1-i]));
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				chan_mode[i] = MODE_OFF;
				chan_duty[i] = '0;
				ramp_dn[i]   = 1'b0;
				pin_latch[i] = 1'b0;
			end
			top_lim = DUTY_TOP_RST;
			bot_lim = DUTY_BOTTOM_RST;
			pins_expected.delete();
			open_words    = 0;
			fail_count    = 0;
			checked_words = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_DUTY_TOP:    top_lim = cfg_data;
					CFG_DUTY_BOTTOM: bot_lim = cfg_data;
					default: begin
					end
				endcase
			end
			if (pins_valid && !pins_stall) compare_pins(pins);
			if (item_valid && !item_stall) apply_item(item);
			open_words = pins_expected.size();
		end
	end

endmodule

FILE: tb/tb_rgb_led_breath_blink_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_led_breath_blink_controller
// Drives the two-LED breathing and blinking controller with a short directed
// sequence, then random set, tick, evaluate and idle words under several duty
// limit settings, with random gaps and stalls on both channels and one long
// hold-off on the pins side. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_rgb_led_breath_blink_controller;
	import rbbc_pkg::*;

	localparam logic [1:0]           LED_NONE_LO      = 2'd0;
	localparam logic [1:0]           LED_NONE_HI      = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI     = 2'd3;
	localparam int                   PHASES           = 7;
	localparam int                   RANDOM_PER_PHASE = 86;
	localparam int                   DRAIN_CYCLES     = 6;
	localparam int                   HOLD_OFF_CYCLES  = 150;

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	item_word_t           item;
	logic                 pins_valid;
	logic                 pins_stall;
	pins_word_t           pins;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [DUTY_W-1:0]    cfg_data;

	int fail_count;
	int open_words;
	int checked_words;

	bit feed_gaps_on;
	bit sink_gaps_on;
	int backpressure_len;
	int sent_set;
	int sent_tick;
	int sent_eval;
	int sent_none;
	int limit_settings;

	rgb_led_breath_blink_controller i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.pins_valid (pins_valid),
		.pins_stall (pins_stall),
		.pins       (pins),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data)
	);

	rbbc_pins_checker i_pins_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.item          (item),
		.pins_valid    (pins_valid),
		.pins_stall    (pins_stall),
		.pins          (pins),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.open_words    (open_words),
		.checked_words (checked_words)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic item_word_t compose(input req_t r, input logic [1:0] led,
		input logic [1:0] col, input mode_t m, input logic [TIME_W-1:0] t,
		input logic [DUTY_W-1:0] pwm);
		item_word_t w;
		w.req_type      = r;
		w.led_sel       = led;
		w.colour        = col;
		w.mode          = m;
		w.time_ms       = t;
		w.pwm_red_one   = pwm;
		w.pwm_green_one = pwm;
		w.pwm_blue_one  = pwm;
		w.pwm_red_two   = pwm;
		w.pwm_green_two = pwm;
		w.pwm_blue_two  = pwm;
		return w;
	endfunction

	function automatic item_word_t random_word();
		int         pick;
		item_word_t w;
		pick = $urandom_range(0, 99);
		w.req_type = (pick < 18) ? REQ_SET : (pick < 55) ? REQ_TICK : (pick < 97) ? REQ_EVAL :
			REQ_NONE;
		if ($urandom_range(0, 9) == 0) begin
			w.led_sel = $urandom_range(0, 1) ? LED_NONE_HI : LED_NONE_LO;
		end else begin
			w.led_sel = $urandom_range(0, 1) ? LED_TWO : LED_ONE;
		end
		w.colour = 2'($urandom_range(0, 3));
		w.mode   = ($urandom_range(0, 2) == 0) ? MODE_BREATH : 2'($urandom_range(0, 3));
		if ($urandom_range(0, 3) == 0) begin
			w.time_ms = BLINK_PERIOD * $urandom_range(0, 8_000_000) + $urandom_range(245, 255);
		end else begin
			w.time_ms = $urandom();
		end
		w.pwm_red_one   = 8'($urandom_range(0, 255));
		w.pwm_green_one = 8'($urandom_range(0, 255));
		w.pwm_blue_one  = 8'($urandom_range(0, 255));
		w.pwm_red_two   = 8'($urandom_range(0, 255));
		w.pwm_green_two = 8'($urandom_range(0, 255));
		w.pwm_blue_two  = 8'($urandom_range(0, 255));
		return w;
	endfunction

	function automatic bit has_no_effect(input item_word_t w);
		return (w.req_type == REQ_NONE) ||
			(w.req_type == REQ_SET && w.led_sel != LED_ONE && w.led_sel != LED_TWO);
	endfunction

	task automatic send_item(input item_word_t w);
		int gap;
		gap = feed_gaps_on ? $urandom_range(0, 16) : 0;
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= w;
		do @(posedge clk); while (item_stall);
		case (req_t'(w.req_type))
			REQ_SET:  sent_set++;
			REQ_TICK: sent_tick++;
			REQ_EVAL: sent_eval++;
			default:  sent_none++;
		endcase
	endtask

	task automatic settle_block();
		@(negedge clk);
		item_valid <= 1'b0;
		while (open_words != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUTY_W-1:0] data);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// While sink gaps are on, the pins side stalls after each taken word for a
	// random count of cycles, and a long hold-off takes over when requested.
	initial begin : pins_sink
		int hold;
		int long_left;
		hold       = 0;
		long_left  = 0;
		pins_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (pins_valid && !pins_stall) begin
				hold = sink_gaps_on ? $urandom_range(0, 16) : 0;
			end
			@(negedge clk);
			if (backpressure_len > 0) begin
				long_left        = backpressure_len;
				backpressure_len = 0;
			end
			if (long_left > 0) begin
				pins_stall <= 1'b1;
				long_left--;
			end else if (hold > 0) begin
				pins_stall <= 1'b1;
				hold--;
			end else begin
				pins_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		item_word_t        w;
		item_word_t        directed [$];
		logic [DUTY_W-1:0] top_val;
		logic [DUTY_W-1:0] bot_val;
		int                done;
		bit                pressed;
		arst_n           = 1'b0;
		item_valid       = 1'b0;
		item             = '0;
		cfg_we           = 1'b0;
		cfg_idx          = CFG_DUTY_TOP;
		cfg_data         = '0;
		feed_gaps_on     = 1'b1;
		sink_gaps_on     = 1'b1;
		backpressure_len = 0;
		sent_set         = 0;
		sent_tick        = 0;
		sent_eval        = 0;
		sent_none        = 0;
		limit_settings   = 1;
		pressed          = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		directed.push_back(compose(REQ_SET, LED_ONE, COLOUR_RED, MODE_ON, '0, '0));
		directed.push_back(compose(REQ_EVAL, LED_ONE, COLOUR_RED, MODE_OFF, '0, '0));
		directed.push_back(compose(REQ_SET, LED_TWO, COLOUR_YELLOW, MODE_BLINK, '0, '0));
		directed.push_back(compose(REQ_EVAL, LED_NONE_LO, COLOUR_RED, MODE_OFF, 32'd250, '0));
		directed.push_back(compose(REQ_EVAL, LED_NONE_LO, COLOUR_RED, MODE_OFF, 32'd251, '0));
		directed.push_back(compose(REQ_EVAL, LED_NONE_HI, COLOUR_YELLOW, MODE_BLINK, '1, '1));
		directed.push_back(compose(REQ_SET, LED_ONE, COLOUR_BLUE, MODE_BREATH, '0, '0));
		directed.push_back(compose(REQ_TICK, LED_ONE, COLOUR_RED, MODE_OFF, '0, '0));
		directed.push_back(compose(REQ_EVAL, LED_ONE, COLOUR_RED, MODE_OFF, 32'd10, 8'd0));
		directed.push_back(compose(REQ_EVAL, LED_ONE, COLOUR_RED, MODE_OFF, 32'd10, 8'd1));
		directed.push_back(compose(REQ_SET, LED_NONE_LO, COLOUR_GREEN, MODE_ON, '0, '0));
		directed.push_back(compose(REQ_SET, LED_NONE_HI, COLOUR_YELLOW, MODE_ON, '0, '0));
		directed.push_back(compose(REQ_NONE, LED_ONE, COLOUR_BLUE, MODE_ON, '1, '1));
		directed.push_back(compose(REQ_SET, LED_TWO, COLOUR_GREEN, MODE_BREATH, '0, '0));
		repeat (3) directed.push_back(compose(REQ_TICK, LED_TWO, COLOUR_RED, MODE_OFF, '0, '0));
		directed.push_back(compose(REQ_SET, LED_TWO, COLOUR_GREEN, MODE_OFF, '0, '0));
		directed.push_back(compose(REQ_TICK, LED_TWO, COLOUR_RED, MODE_OFF, '0, '0));
		directed.push_back(compose(REQ_SET, LED_TWO, COLOUR_GREEN, MODE_BREATH, '0, '0));
		directed.push_back(compose(REQ_EVAL, LED_TWO, COLOUR_RED, MODE_OFF, 32'd0, 8'd3));
		directed.push_back(compose(REQ_EVAL, LED_TWO, COLOUR_RED, MODE_OFF, 32'd499, '1));
		directed.push_back(compose(REQ_SET, LED_ONE, COLOUR_YELLOW, MODE_OFF, '0, '0));
		directed.push_back(compose(REQ_EVAL, LED_ONE, COLOUR_RED, MODE_OFF, 32'd500, 8'd128));
		foreach (directed[i]) send_item(directed[i]);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				case (ph)
					1: begin top_val = 8'd255; bot_val = 8'd254; end
					2: begin top_val = 8'd1;   bot_val = 8'd0;   end
					3: begin top_val = 8'd20;  bot_val = 8'd5;   end
					4: begin top_val = 8'd5;   bot_val = 8'd40;  end
					5: begin top_val = 8'd255; bot_val = 8'd0;   end
					default: begin
						top_val = 8'($urandom_range(1, 255));
						bot_val = 8'($urandom_range(0, 254));
					end
				endcase
				write_reg(CFG_DUTY_TOP, top_val);
				write_reg(CFG_DUTY_BOTTOM, bot_val);
				if (ph == 3) begin
					write_reg(CFG_SPARE_LO, 8'($urandom_range(0, 255)));
					write_reg(CFG_SPARE_HI, 8'($urandom_range(0, 255)));
				end
				limit_settings++;
			end
			done = 0;
			while (done < RANDOM_PER_PHASE) begin
				if (done % 40 == 0) begin
					feed_gaps_on = ($urandom_range(0, 3) != 0);
					sink_gaps_on = ($urandom_range(0, 3) != 0);
				end
				if (ph == 2 && !pressed) begin
					pressed          = 1'b1;
					feed_gaps_on     = 1'b0;
					backpressure_len = HOLD_OFF_CYCLES;
				end
				w = random_word();
				send_item(w);
				if (!has_no_effect(w)) done++;
			end
			settle_block();
		end

		$display("Covered %0d set commands, %0d breath ticks, %0d evaluates and %0d unused words",
			sent_set, sent_tick, sent_eval, sent_none);
		$display("under %0d duty limit settings, crossed and extreme ones included; %0d words checked.",
			limit_settings, checked_words);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
